/* hw/rtl/smr_pkg.sv */
// smr_pkg: shared types, sizes and codes for the segmented message reassembler.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
package smr_pkg;

  localparam int SLOTS         = 4;
  localparam int MAX_SEGMENTS  = 32;
  localparam int MAX_SEG_BYTES = 16;
  localparam int SLOT_BYTES    = MAX_SEGMENTS * MAX_SEG_BYTES;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int SEG_W   = 5;
  localparam int BIDX_W  = 4;
  localparam int SIZE_W  = 5;
  localparam int LEN_W   = 5;
  localparam int CNT_W   = SEG_W + 1;
  localparam int TOT_W   = 10;
  localparam int BADDR_W = $clog2(SLOT_BYTES);
  localparam int RIDX_W  = 9;
  localparam int LIM_W   = SIZE_W + CNT_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(12);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_PEND  = 3'd0,
    ST_DONE  = 3'd1,
    ST_FULL  = 3'd2,
    ST_MAL   = 3'd3,
    ST_READ  = 3'd4,
    ST_CLR   = 3'd5
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [15:0]       src;
    logic [23:0]       seq;
    logic [SEG_W-1:0]  seg_offset;
    logic [SEG_W-1:0]  seg_last;
    logic [BIDX_W-1:0] byte_index;
    logic [7:0]        byte_value;
    logic              end_of_segment;
    logic [1:0]        slot;
    logic [RIDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [1:0]       result_slot;
    logic [TOT_W-1:0] total_length;
    logic [7:0]       read_byte;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;
    logic load;
    logic eval;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/smr_if.sv */
// smr_if: valid/ready channel interfaces for input words, result words and config.
// Depends on smr_pkg.
`timescale 1ns / 1ps
interface smr_in_if;
  import smr_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface smr_out_if;
  import smr_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface smr_cfg_if;
  import smr_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* hw/rtl/segmented_message_reassembler_top.sv */
// Segmented message reassembler: one request word in, one result word out per word;
// a word is evaluated (table lookup and memory access), then finished (length and
// completion update); the next word is taken at that finish, once the output is free.
// Words do not overlap: the finish step updates the fill counters and the length memory
// that the next word's lookup reads. Up to 4 messages
// keyed by source and sequence are held; completion uses per-slot fill counters, so no
// scan over segments takes place. No clearing pass is needed after reset.
// Depends on smr_pkg, smr_if, smr_ctrl and smr_dp.
`timescale 1ns / 1ps
module segmented_message_reassembler_top (
  input  logic      clk,
  input  logic      rst,
  smr_in_if.sink    in_ch,
  smr_out_if.source out_ch,
  smr_cfg_if.sink   cfg_ch
);
  import smr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  smr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  smr_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

/* hw/rtl/smr_ctrl.sv */
// smr_ctrl: sequencing state machine (accept, evaluate, finish).
// Depends on smr_pkg.
`timescale 1ns / 1ps
module smr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  smr_pkg::stat_t stat,
  output smr_pkg::cmd_t  cmd
);
  import smr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd.finish   = (state == S_FIN) && stat.out_free;
    cmd.eval     = (state == S_EVAL);
    cmd.in_ready = (state == S_IDLE) || cmd.finish;
    cmd.load     = cmd.in_ready && stat.in_valid;
    state_next   = state;
    unique case (state)
      S_IDLE: if (cmd.load) state_next = S_EVAL;
      S_EVAL: state_next = S_FIN;
      S_FIN: begin
        if (cmd.finish) state_next = cmd.load ? S_EVAL : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_eval_then_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |=> state == S_FIN) else $error("eval not followed by finish");
  a_load_to_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.eval) else $error("accepted word not evaluated");
  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !stat.out_free |=> state == S_FIN) else $error("finish lost");

endmodule

/* hw/rtl/smr_dp.sv */
// smr_dp: slot table, length and byte memories, per-slot fill counters, result register.
// Depends on smr_pkg and smr_if.
`timescale 1ns / 1ps
module smr_dp (
  input  logic           clk,
  input  logic           rst,
  input  smr_pkg::cmd_t  cmd,
  output smr_pkg::stat_t stat,
  smr_in_if.sink         in_ch,
  smr_out_if.source      out_ch,
  smr_cfg_if.sink        cfg_ch
);
  import smr_pkg::*;

  typedef struct packed {
    status_t          st;
    logic [SLOT_W-1:0] slot;
    logic [SEG_W-1:0] off;
    logic [SEG_W-1:0] last;
    logic             eos;
    logic [LEN_W-1:0] len_new;
    logic             rd_in;
    logic             do_len;
  } dec_t;

  localparam int LADDR_W = SLOT_W + SEG_W;

  logic [SIZE_W-1:0] seg_size;
  item_t             item;
  dec_t              dec, dec_n;

  logic [SLOTS-1:0]  slot_valid;
  logic [15:0]       slot_source   [SLOTS];
  logic [23:0]       slot_sequence [SLOTS];
  logic [SEG_W-1:0]  slot_last     [SLOTS];
  logic [CNT_W-1:0]  seg_cnt       [SLOTS];
  logic [TOT_W-1:0]  seg_tot       [SLOTS];

  logic [LEN_W-1:0]  len_mem [SLOTS*MAX_SEGMENTS];
  logic [SLOTS*MAX_SEGMENTS-1:0] len_vld;
  logic [LEN_W-1:0]  len_rdata;
  logic              old_vld;
  logic [7:0]        byte_mem [SLOTS*SLOT_BYTES];
  logic [7:0]        byte_rdata;

  logic              out_valid;
  result_t           out_data;

  // lookup
  logic              m_found, f_found;
  logic [SLOT_W-1:0] m_idx, f_idx, tbl_idx, wslot;
  logic [SEG_W-1:0]  tbl_last, last;
  logic [SIZE_W-1:0] size;
  logic              bad, wr_ok, alloc, clr;
  logic [9:0]        prod;
  logic [BADDR_W-1:0] baddr;
  logic [LIM_W-1:0]  limit;
  logic [LADDR_W-1:0] laddr, fin_laddr;

  // finish
  logic [LEN_W-1:0]  old_len;
  logic [CNT_W-1:0]  cnt_n;
  logic [TOT_W-1:0]  tot_n;
  logic              complete;

  assign cfg_ch.ready  = 1'b1;
  assign in_ch.ready   = cmd.in_ready;
  assign stat.in_valid = in_ch.valid;
  assign stat.out_free = !out_valid || out_ch.ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.data   = out_data;

  always_comb begin
    m_found = 1'b0;
    f_found = 1'b0;
    m_idx   = '0;
    f_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i]) begin
        if (!m_found && slot_source[i] == item.src && slot_sequence[i] == item.seq) begin
          m_found = 1'b1;
          m_idx   = SLOT_W'(i);
        end
      end else if (!f_found) begin
        f_found = 1'b1;
        f_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    if (seg_size == '0) begin
      size = SIZE_W'(1);
    end else if (seg_size > SIZE_W'(MAX_SEG_BYTES)) begin
      size = SIZE_W'(MAX_SEG_BYTES);
    end else begin
      size = seg_size;
    end
    tbl_idx  = (item.op == OP_READ) ? item.slot[SLOT_W-1:0] : m_idx;
    tbl_last = slot_last[tbl_idx];
    last     = m_found ? tbl_last : item.seg_last;
    wslot    = m_found ? m_idx : f_idx;
    bad = ({1'b0, last} >= CNT_W'(MAX_SEGMENTS)) || (item.seg_offset > last) ||
          ({1'b0, item.byte_index} >= size) ||
          (item.end_of_segment && item.seg_offset != last &&
           ({1'b0, item.byte_index} + SIZE_W'(1) < size));
    prod  = item.seg_offset * size;
    baddr = BADDR_W'(prod + 10'(item.byte_index));
    limit = LIM_W'(size) * (LIM_W'(tbl_last) + LIM_W'(1));
    laddr = {wslot, item.seg_offset};

    wr_ok = 1'b0;
    alloc = 1'b0;
    clr   = 1'b0;
    dec_n = '0;
    dec_n.off     = item.seg_offset;
    dec_n.last    = last;
    dec_n.eos     = item.end_of_segment;
    dec_n.len_new = LEN_W'(item.byte_index) + LEN_W'(1);
    dec_n.rd_in   = LIM_W'(item.read_index) < limit;
    unique case (item.op)
      OP_WRITE: begin
        if (!m_found && !f_found) begin
          dec_n.st = ST_FULL;
        end else if (bad) begin
          dec_n.st   = ST_MAL;
          dec_n.slot = m_found ? m_idx : '0;
        end else begin
          dec_n.st     = ST_PEND;
          dec_n.slot   = wslot;
          dec_n.do_len = 1'b1;
          wr_ok        = 1'b1;
          alloc        = !m_found;
        end
      end
      OP_READ: begin
        if (slot_valid[item.slot[SLOT_W-1:0]]) begin
          dec_n.st   = ST_READ;
          dec_n.slot = item.slot[SLOT_W-1:0];
        end else begin
          dec_n.st = ST_MAL;
        end
      end
      OP_CLEAR: begin
        dec_n.st   = ST_CLR;
        dec_n.slot = item.slot[SLOT_W-1:0];
        clr        = 1'b1;
      end
      default: dec_n.st = ST_MAL;
    endcase
  end

  // per-segment length update; a fresh row reads as zero
  always_comb begin
    old_len   = old_vld ? len_rdata : '0;
    fin_laddr = {dec.slot, dec.off};
    cnt_n     = seg_cnt[dec.slot];
    tot_n     = seg_tot[dec.slot];
    if (dec.eos) begin
      if (old_len == '0) cnt_n = cnt_n + CNT_W'(1);
      tot_n = tot_n + TOT_W'(dec.len_new) - TOT_W'(old_len);
    end
    complete = dec.do_len && (cnt_n == CNT_W'(dec.last) + CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size   <= SIZE_RESET;
      slot_valid <= '0;
      len_vld    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_ch.valid) seg_size <= cfg_ch.data;
      if (cmd.eval && alloc) begin
        slot_valid[wslot] <= 1'b1;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
          len_vld[{wslot, SEG_W'(i)}] <= 1'b0;
        end
      end
      if (cmd.eval && clr) slot_valid[item.slot[SLOT_W-1:0]] <= 1'b0;
      if (cmd.finish && dec.do_len && dec.eos) len_vld[fin_laddr] <= 1'b1;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_ch.data;
    if (cmd.eval) begin
      dec     <= dec_n;
      old_vld <= !alloc && len_vld[laddr];
      if (alloc) begin
        slot_source[wslot]   <= item.src;
        slot_sequence[wslot] <= item.seq;
        slot_last[wslot]     <= last;
        seg_cnt[wslot]       <= '0;
        seg_tot[wslot]       <= '0;
      end
    end
    if (cmd.finish && dec.do_len) begin
      seg_cnt[dec.slot] <= cnt_n;
      seg_tot[dec.slot] <= tot_n;
    end
    if (cmd.finish) begin
      out_data.status       <= (dec.st == ST_PEND && complete) ? ST_DONE : dec.st;
      out_data.result_slot  <= 2'(dec.slot);
      out_data.total_length <= complete ? tot_n : '0;
      out_data.read_byte    <= (dec.st == ST_READ && dec.rd_in) ? byte_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    len_rdata <= len_mem[laddr];
    if (cmd.finish && dec.do_len && dec.eos) len_mem[fin_laddr] <= dec.len_new;
  end

  always_ff @(posedge clk) begin
    byte_rdata <= byte_mem[{item.slot[SLOT_W-1:0], item.read_index[BADDR_W-1:0]}];
    if (cmd.eval && wr_ok) byte_mem[{wslot, baddr}] <= item.byte_value;
  end

  a_alloc_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.eval && alloc |=> slot_valid[$past(wslot)]) else $error("allocated slot not valid");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("finished word not presented");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && dec.do_len |-> cnt_n <= CNT_W'(dec.last) + CNT_W'(1))
    else $error("segment count beyond last");
  a_done_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_DONE |-> out_data.total_length != '0)
    else $error("complete with zero length");

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking bench for segmented_message_reassembler_top.
// Directed table plus random message traffic, checked against an in-bench reassembly model.
// Depends on smr_pkg, smr_if and the RTL top.
`timescale 1ns / 1ps
module testbench;
  import smr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  smr_in_if  in_ch();
  smr_out_if out_ch();
  smr_cfg_if cfg_ch();

  segmented_message_reassembler_top uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // reassembly table shadow
  logic [SIZE_W-1:0] seg_size_q;
  bit                tbl_vld [SLOTS];
  logic [15:0]       tbl_src [SLOTS];
  logic [23:0]       tbl_seq [SLOTS];
  logic [SEG_W-1:0]  tbl_last [SLOTS];
  logic [LEN_W-1:0]  tbl_len [SLOTS][MAX_SEGMENTS];
  logic [7:0]        buf_byte [SLOTS*SLOT_BYTES];
  bit                buf_wr [SLOTS*SLOT_BYTES];

  result_t pending_results[$];
  int      mismatches = 0;
  int      snd_idle = 14;
  int      rcv_idle = 47;
  logic    long_stall = 1'b0;
  bit      stall_go = 1'b0;
  int      words_sent = 0;

  function automatic int eff_seg_size();
    if (seg_size_q == 0) return 1;
    if (seg_size_q > MAX_SEG_BYTES) return MAX_SEG_BYTES;
    return int'(seg_size_q);
  endfunction

  function automatic int read_limit(int s);
    int lim;
    lim = eff_seg_size() * (int'(tbl_last[s]) + 1);
    return (lim > SLOT_BYTES) ? SLOT_BYTES : lim;
  endfunction

  function automatic result_t mk_res(status_t st, int sl, int tot, int b);
    result_t r;
    r.status       = st;
    r.result_slot  = 2'(sl);
    r.total_length = TOT_W'(tot);
    r.read_byte    = 8'(b);
    return r;
  endfunction

  // advances the shadow table by one word and returns its result
  function automatic result_t reassemble_step(item_t it);
    int match, fre, s, es, lst, addr, tot;
    match = -1;
    fre   = -1;
    es    = eff_seg_size();
    case (it.op)
      OP_WRITE: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (tbl_vld[k]) begin
            if (match < 0 && tbl_src[k] == it.src && tbl_seq[k] == it.seq) match = k;
          end else if (fre < 0) begin
            fre = k;
          end
        end
        if (match < 0 && fre < 0) return mk_res(ST_FULL, 0, 0, 0);
        lst = (match >= 0) ? int'(tbl_last[match]) : int'(it.seg_last);
        if (lst >= MAX_SEGMENTS || int'(it.seg_offset) > lst || int'(it.byte_index) >= es ||
            (it.end_of_segment && int'(it.seg_offset) != lst && int'(it.byte_index) + 1 < es))
          return mk_res(ST_MAL, (match >= 0) ? match : 0, 0, 0);
        if (match < 0) begin
          s = fre;
          tbl_vld[s]  = 1'b1;
          tbl_src[s]  = it.src;
          tbl_seq[s]  = it.seq;
          tbl_last[s] = SEG_W'(lst);
          for (int k = 0; k < MAX_SEGMENTS; k++) tbl_len[s][k] = '0;
        end else begin
          s = match;
        end
        addr = s * SLOT_BYTES + int'(it.seg_offset) * es + int'(it.byte_index);
        buf_byte[addr] = it.byte_value;
        buf_wr[addr]   = 1'b1;
        if (it.end_of_segment) tbl_len[s][it.seg_offset] = LEN_W'(it.byte_index + 1);
        tot = 0;
        for (int k = 0; k <= lst; k++) begin
          if (tbl_len[s][k] == 0) return mk_res(ST_PEND, s, 0, 0);
          tot += int'(tbl_len[s][k]);
        end
        return mk_res(ST_DONE, s, tot, 0);
      end
      OP_READ: begin
        if (!tbl_vld[it.slot]) return mk_res(ST_MAL, 0, 0, 0);
        if (int'(it.read_index) >= read_limit(it.slot)) return mk_res(ST_READ, it.slot, 0, 0);
        return mk_res(ST_READ, it.slot, 0, buf_byte[it.slot * SLOT_BYTES + it.read_index]);
      end
      OP_CLEAR: begin
        tbl_vld[it.slot] = 1'b0;
        return mk_res(ST_CLR, it.slot, 0, 0);
      end
      default: return mk_res(ST_MAL, 0, 0, 0);
    endcase
  endfunction

  function automatic item_t mk_wr(int src, int seq, int off, int lst, int bi, int val, bit eos);
    item_t it;
    it = '0;
    it.op = OP_WRITE;
    it.src = 16'(src);
    it.seq = 24'(seq);
    it.seg_offset = SEG_W'(off);
    it.seg_last = SEG_W'(lst);
    it.byte_index = BIDX_W'(bi);
    it.byte_value = 8'(val);
    it.end_of_segment = eos;
    it.slot = 2'($urandom_range(3));
    it.read_index = RIDX_W'($urandom_range(511));
    return it;
  endfunction

  function automatic item_t mk_op(op_t op, int sl, int ri);
    item_t it;
    it = item_t'({$urandom, $urandom, $urandom});
    it.op = op;
    it.slot = 2'(sl);
    it.read_index = RIDX_W'(ri);
    return it;
  endfunction

  // keeps a read away from buffer bytes that were never written
  function automatic item_t safe_read(item_t it);
    int lim, ri;
    if (it.op != OP_READ || !tbl_vld[it.slot]) return it;
    lim = read_limit(it.slot);
    if (int'(it.read_index) >= lim || buf_wr[it.slot * SLOT_BYTES + it.read_index]) return it;
    for (int k = 0; k < 24; k++) begin
      ri = $urandom_range(lim - 1);
      if (buf_wr[it.slot * SLOT_BYTES + ri]) begin
        it.read_index = RIDX_W'(ri);
        return it;
      end
    end
    if (lim < SLOT_BYTES) it.read_index = RIDX_W'($urandom_range(511, lim));
    else it.op = OP_NONE;
    return it;
  endfunction

  task automatic send_word(item_t it, bit typed = 1'b0, result_t exp_res = '0);
    result_t r;
    if ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    r = reassemble_step(it);
    pending_results.push_back(typed ? exp_res : r);
    words_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_seg_size(int v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= SIZE_W'(v);
    do @(posedge clk); while (!cfg_ch.ready);
    seg_size_q = SIZE_W'(v);
    cfg_ch.valid <= 1'b0;
  endtask

  // one message, segments in random order; sometimes broken or left unfinished
  task automatic send_message();
    int src, seq, lst, es, len, perm[$], tmp, sl;
    es  = eff_seg_size();
    src = $urandom_range(65535);
    seq = $urandom_range(24'hFFFFFF);
    lst = (es <= 2 && $urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(3);
    if (tbl_vld[0] && tbl_vld[1] && tbl_vld[2] && tbl_vld[3] && $urandom_range(9) < 8)
      send_word(mk_op(OP_CLEAR, $urandom_range(3), 0));
    for (int k = 0; k <= lst; k++) perm.push_back(k);
    perm.shuffle();
    foreach (perm[k]) begin
      len = (perm[k] == lst) ? $urandom_range(1, es) : es;
      if ($urandom_range(19) == 0) len = $urandom_range(1, es);
      for (int b = 0; b < len; b++) begin
        if ($urandom_range(39) == 0)
          send_word(mk_wr(src, seq, $urandom_range(31), lst, $urandom_range(15),
                          $urandom_range(255), $urandom_range(1)));
        else
          send_word(mk_wr(src, seq, perm[k], lst, b, $urandom_range(255), b == len - 1));
      end
      if ($urandom_range(29) == 0) break;
    end
    for (int k = $urandom_range(3); k > 0; k--) begin
      sl = $urandom_range(3);
      tmp = tbl_vld[sl] ? $urandom_range(read_limit(sl) + 8 > 511 ? 511 : read_limit(sl) + 8)
                        : $urandom_range(511);
      send_word(safe_read(mk_op(OP_READ, sl, tmp)));
    end
    if ($urandom_range(3) == 0) send_word(mk_op(OP_CLEAR, $urandom_range(3), 0));
  endtask

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_ch.data);
      end else begin
        e = pending_results.pop_front();
        if (out_ch.data.status !== e.status || out_ch.data.result_slot !== e.result_slot ||
            out_ch.data.total_length !== e.total_length ||
            out_ch.data.read_byte !== e.read_byte) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, out_ch.data);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= !long_stall && ($urandom_range(99) >= rcv_idle);
  end

  // long receiver hold so the block backs up into its input
  initial begin
    wait (stall_go);
    @(posedge clk);
    long_stall <= 1'b1;
    repeat (300) @(posedge clk);
    long_stall <= 1'b0;
  end

  initial begin
    #1600000;
    $display("[segmented_message_reassembler_top] ERROR");
    $finish;
  end

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } dir_row_t;

  initial begin
    dir_row_t dir_rows[$];
    int seg_sizes[6] = '{1, 16, 0, 31, 5, 12};
    int target;

    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    seg_size_q   = SIZE_RESET;
    foreach (tbl_vld[k]) tbl_vld[k] = 1'b0;
    foreach (buf_wr[k]) buf_wr[k] = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed rows at the reset segment size
    dir_rows = '{
      '{mk_op(OP_READ, 0, 0), 1, mk_res(ST_MAL, 0, 0, 0)},
      '{mk_op(OP_NONE, 1, 5), 1, mk_res(ST_MAL, 0, 0, 0)},
      '{mk_op(OP_CLEAR, 3, 0), 1, mk_res(ST_CLR, 3, 0, 0)},
      '{mk_wr(16'hFFFF, 24'hFFFFFF, 0, 0, 0, 8'hFF, 1), 1, mk_res(ST_DONE, 0, 1, 0)},
      '{mk_op(OP_READ, 0, 0), 1, mk_res(ST_READ, 0, 0, 8'hFF)},
      '{mk_op(OP_READ, 0, 511), 1, mk_res(ST_READ, 0, 0, 0)},
      '{mk_wr(1, 1, 2, 1, 0, 8'h11, 0), 1, mk_res(ST_MAL, 0, 0, 0)},
      '{mk_wr(1, 1, 0, 31, 15, 8'h22, 0), 1, mk_res(ST_MAL, 0, 0, 0)},
      '{mk_wr(1, 1, 0, 31, 0, 8'h33, 1), 1, mk_res(ST_MAL, 0, 0, 0)},
      '{mk_wr(1, 1, 0, 1, 11, 8'h5A, 1), 1, mk_res(ST_PEND, 1, 0, 0)},
      '{mk_wr(1, 1, 1, 5, 3, 8'hA5, 1), 1, mk_res(ST_DONE, 1, 16, 0)},
      '{mk_wr(1, 1, 1, 0, 0, 8'h00, 0), 1, mk_res(ST_DONE, 1, 16, 0)},
      '{mk_wr(2, 2, 31, 31, 0, 8'h80, 0), 1, mk_res(ST_PEND, 2, 0, 0)},
      '{mk_wr(3, 3, 0, 0, 11, 8'h7F, 0), 1, mk_res(ST_PEND, 3, 0, 0)},
      '{mk_wr(4, 4, 0, 0, 0, 8'h01, 1), 1, mk_res(ST_FULL, 0, 0, 0)},
      '{mk_op(OP_READ, 2, 372), 0, '0},
      '{mk_op(OP_READ, 1, 11), 0, '0},
      '{mk_op(OP_READ, 1, 24), 1, mk_res(ST_READ, 1, 0, 0)},
      '{mk_op(OP_CLEAR, 0, 0), 1, mk_res(ST_CLR, 0, 0, 0)},
      '{mk_op(OP_CLEAR, 0, 0), 1, mk_res(ST_CLR, 0, 0, 0)},
      '{mk_wr(4, 4, 0, 0, 0, 8'h01, 1), 0, '0},
      '{mk_wr(16'h8000, 24'h800000, 16, 31, 8, 8'hC3, 1), 0, '0},
      '{mk_op(OP_READ, 3, 11), 0, '0}
    };
    foreach (dir_rows[k]) send_word(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);

    // random traffic across segment sizes and idle modes
    foreach (seg_sizes[p]) begin
      drain();
      write_seg_size(seg_sizes[p]);
      snd_idle = (p < 2) ? 14 : (p < 4) ? 47 : 0;
      rcv_idle = (p < 2) ? 47 : (p < 4) ? 14 : 0;
      if (p == 1) stall_go = 1'b1;
      target = words_sent + 65;
      while (words_sent < target) begin
        if ($urandom_range(6) == 0)
          send_word(safe_read(item_t'({$urandom, $urandom, $urandom})));
        else
          send_message();
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("[segmented_message_reassembler_top] OK");
    else
      $display("[segmented_message_reassembler_top] ERROR");
    $finish;
  end
endmodule
